>>> rtl/core/assert_macros.svh
// Assertion macros shared by the stencil sweep RTL.
// Every check is sampled on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form with an explicit clock and reset.
`define JSS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Usual form on the block clock, switched off while reset is high.
`define JSS_ASSERT(label, prop, msg) \
   `JSS_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

>>> rtl/core/jss_pkg.sv
package jss_pkg;

   // Field widths of the stream and configuration ports.
   localparam int VALUE_W    = 24;
   localparam int GRID_W     = 10;
   localparam int POS_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 72;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS = 2'd0,
      CSR_GRID_COLS = 2'd1,
      CSR_EPSILON   = 2'd2
   } csr_index_type;

   // Stencil neighbors of one grid point, as read from the line buffers.
   typedef struct packed {
      logic [VALUE_W-1:0] north;
      logic [VALUE_W-1:0] south;
      logic [VALUE_W-1:0] center;
      logic [VALUE_W-1:0] east;
   } taps_type;

   // Position flags of the beat held in stage one.
   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             emit;
      logic             last;
      logic             pre_clr;
      logic             post_clr;
   } pos_info_type;

   // One result beat.
   typedef struct packed {
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [VALUE_W-1:0] new_temperature;
      logic               sweep_end;
      logic [VALUE_W-1:0] max_change;
      logic               converged;
   } result_type;

endpackage

>>> rtl/core/jss_line_buf.sv
module jss_line_buf
   import jss_pkg::*;
#(
   parameter int MAX_COLS = 512,
   localparam int AW = $clog2(MAX_COLS)
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   input  logic [VALUE_W-1:0] south_in,
   input  logic               wr2_en,
   output taps_type           taps
);

   logic [VALUE_W-1:0] prev_mem  [MAX_COLS];
   logic [VALUE_W-1:0] prev2_mem [MAX_COLS];
   logic [AW-1:0]      east_addr;
   logic [AW-1:0]      addr_ff;
   taps_type           taps_ff;

   // The east neighbor sits one column to the right in the previous row.
   assign east_addr = (rd_addr == AW'(MAX_COLS - 1)) ? '0 : rd_addr + AW'(1);

   // Accepted beat: read the column taps and store the new south value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         prev_mem[rd_addr] <= south_in;
         taps_ff.center    <= prev_mem[rd_addr];
         taps_ff.east      <= prev_mem[east_addr];
         taps_ff.north     <= prev2_mem[rd_addr];
         taps_ff.south     <= south_in;
         addr_ff           <= rd_addr;
      end
   end

   // The old center moves down into the older row while the beat is in stage one.
   always_ff @(posedge clock) begin
      if (wr2_en) begin
         prev2_mem[addr_ff] <= taps_ff.center;
      end
   end

   assign taps = taps_ff;

endmodule

>>> rtl/core/jss_pos_ctrl.sv
module jss_pos_ctrl
   import jss_pkg::*;
#(
   parameter int MAX_COLS = 512,
   parameter int MAX_ROWS = 512,
   localparam int AW = $clog2(MAX_COLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [GRID_W-1:0] grid_rows,
   input  logic [GRID_W-1:0] grid_cols,
   input  logic              accept,
   input  logic              s1_adv,
   output logic [AW-1:0]     rd_addr,
   output logic              s1_valid,
   output pos_info_type      s1_info
);

`include "assert_macros.svh"

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int RCW = RW + 1;
   localparam int CCW = AW + 1;
   localparam int REW = (RCW > GRID_W) ? RCW : GRID_W;
   localparam int CEW = (CCW > GRID_W) ? CCW : GRID_W;
   localparam int RXW = (RCW > POS_W) ? RCW : POS_W;
   localparam int CXW = (CCW > POS_W) ? CCW : POS_W;

   logic [RW-1:0]     row_cnt_ff, row_cnt_in;
   logic [AW-1:0]     col_cnt_ff, col_cnt_in;
   logic              s1_valid_ff;
   pos_info_type      s1_info_ff, info;
   logic [REW-1:0]    rows_ext;
   logic [CEW-1:0]    cols_ext;
   logic [RCW-1:0]    rows_eff, r_pre, r_cur, r_next;
   logic [CCW-1:0]    cols_eff, c_cur, c_next, c_plus2;
   logic              col_wrap, pre_clr, post_clr, col_end;
   logic [RXW-1:0]    row_m1;
   logic [CXW-1:0]    col_x;

   // Clamp the grid size to the supported range.
   always_comb begin
      rows_ext = REW'(grid_rows);
      cols_ext = CEW'(grid_cols);
      if (rows_ext < REW'(3)) begin
         rows_eff = RCW'(3);
      end else if (rows_ext > REW'(MAX_ROWS)) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(rows_ext);
      end
      if (cols_ext < CEW'(3)) begin
         cols_eff = CCW'(3);
      end else if (cols_ext > CEW'(MAX_COLS)) begin
         cols_eff = CCW'(MAX_COLS);
      end else begin
         cols_eff = CCW'(cols_ext);
      end
   end

   // Position of the next beat, wrapped if the grid shrank under the counters.
   always_comb begin
      col_wrap = CCW'(col_cnt_ff) >= cols_eff;
      r_pre    = col_wrap ? RCW'(row_cnt_ff) + RCW'(1) : RCW'(row_cnt_ff);
      pre_clr  = r_pre >= rows_eff;
      r_cur    = pre_clr ? '0 : r_pre;
      c_cur    = col_wrap ? '0 : CCW'(col_cnt_ff);
      c_plus2  = c_cur + CCW'(2);

      info.emit     = (r_cur >= RCW'(2)) && (c_cur >= CCW'(1)) && (c_plus2 <= cols_eff);
      info.last     = (r_cur + RCW'(1) == rows_eff) && (c_plus2 == cols_eff);
      info.pre_clr  = pre_clr;
      row_m1        = RXW'(r_cur) - RXW'(1);
      col_x         = CXW'(c_cur);
      info.row      = row_m1[POS_W-1:0];
      info.col      = col_x[POS_W-1:0];

      // Advance past this beat.
      c_next   = c_cur + CCW'(1);
      col_end  = c_next >= cols_eff;
      r_next   = col_end ? r_cur + RCW'(1) : r_cur;
      post_clr = col_end && (r_next >= rows_eff);
      info.post_clr = post_clr;
      col_cnt_in = col_end ? '0 : c_next[AW-1:0];
      row_cnt_in = post_clr ? '0 : r_next[RW-1:0];
   end

   assign rd_addr = c_cur[AW-1:0];

   // Counters and the stage one valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff  <= '0;
         col_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            row_cnt_ff  <= row_cnt_in;
            col_cnt_ff  <= col_cnt_in;
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Position flags travel with the beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_info  = s1_info_ff;

   `JSS_ASSERT(a_s1_fill, accept |=> s1_valid_ff, "accepted beat missing from stage one")
   `JSS_ASSERT(a_post_no_emit, s1_valid_ff && s1_info_ff.post_clr |-> !s1_info_ff.emit, "grid end position flagged for a result")

endmodule

>>> rtl/core/jss_stencil.sv
module jss_stencil
   import jss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  pos_info_type       s1_info,
   input  taps_type           taps,
   input  logic [VALUE_W-1:0] epsilon,
   input  logic               rsp_tready,
   output logic               s1_adv,
   output logic               rsp_tvalid,
   output result_type         rsp_result
);

`include "assert_macros.svh"

   logic [VALUE_W-1:0] west_ff;
   logic [VALUE_W-1:0] run_max_ff, run_max_in;
   logic               rsp_valid_ff;
   result_type         result_ff, result_in;
   logic [VALUE_W+1:0] sum;
   logic [VALUE_W-1:0] avg, diff, base, newmax;
   logic               out_free, out_load;

   // Stage one drains when it has no result or the output register is free.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_adv   = s1_valid && (!s1_info.emit || out_free);
   assign out_load = s1_valid && s1_info.emit && out_free;

   // Four-point average and the change against the old value.
   always_comb begin
      sum    = {2'b00, taps.north} + {2'b00, taps.south} + {2'b00, west_ff}
             + {2'b00, taps.east};
      avg    = sum[VALUE_W+1:2];
      diff   = (avg >= taps.center) ? avg - taps.center : taps.center - avg;
      base   = s1_info.pre_clr ? '0 : run_max_ff;
      newmax = (s1_info.emit && (diff > base)) ? diff : base;
      run_max_in = (s1_info.last || s1_info.post_clr) ? '0 : newmax;

      result_in.row             = s1_info.row;
      result_in.col             = s1_info.col;
      result_in.new_temperature = avg;
      result_in.sweep_end       = s1_info.last;
      result_in.max_change      = s1_info.last ? newmax : '0;
      result_in.converged       = s1_info.last && (newmax < epsilon);
   end

   // West window, running maximum and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         west_ff      <= '0;
         run_max_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            west_ff    <= taps.center;
            run_max_ff <= run_max_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = result_ff;

   `JSS_ASSERT(a_conv_at_end, rsp_valid_ff && result_ff.converged |-> result_ff.sweep_end, "converged flag outside a sweep end")
   `JSS_ASSERT(a_max_clear, out_load && s1_info.last |=> (run_max_ff == '0), "running maximum kept after sweep end")

endmodule

>>> rtl/core/jacobi_stencil_sweep_top.sv
// Channel  Dir  Beat contents
// req      in   temperature, next grid value in row-major order
// rsp      out  one interior point: new value, position, sweep status
// csr      in   register writes: grid_rows, grid_cols, epsilon
//
// One beat is accepted per cycle unless a stalled rsp channel holds stage
// one; the result of the beat that completes its stencil is registered in
// the line buffer read register and then in the output register.
// Reset clears the counters, the running maximum and both valid flags;
// the line buffers are not cleared.
// A stalled rsp channel holds one result and one beat in stage one before
// req_tready drops.
module jacobi_stencil_sweep_top
   import jss_pkg::*;
#(
   parameter int MAX_COLS = 512,
   parameter int MAX_ROWS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: temperature [23:0]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: row [8:0], col [17:9], new_temperature [41:18],
   // max_change [65:42], converged [66], zero [71:67]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_COLS);

   logic [GRID_W-1:0]  grid_rows_ff;
   logic [GRID_W-1:0]  grid_cols_ff;
   logic [VALUE_W-1:0] epsilon_ff;
   logic               accept, s1_valid, s1_adv;
   logic [AW-1:0]      rd_addr;
   pos_info_type       s1_info;
   taps_type           taps;
   result_type         result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_W'(500);
         grid_cols_ff <= GRID_W'(500);
         epsilon_ff   <= VALUE_W'(66);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[GRID_W-1:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata[GRID_W-1:0];
            CSR_EPSILON:   epsilon_ff   <= csr_wdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage one takes a new beat whenever it is empty or drains.
   assign req_tready = !s1_valid || s1_adv;
   assign accept     = req_tvalid && req_tready;

   jss_pos_ctrl #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_pos_ctrl (
      .clock     (clock),
      .reset     (reset),
      .grid_rows (grid_rows_ff),
      .grid_cols (grid_cols_ff),
      .accept    (accept),
      .s1_adv    (s1_adv),
      .rd_addr   (rd_addr),
      .s1_valid  (s1_valid),
      .s1_info   (s1_info)
   );

   jss_line_buf #(
      .MAX_COLS (MAX_COLS)
   ) u_line_buf (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .south_in (req_tdata[VALUE_W-1:0]),
      .wr2_en   (s1_valid),
      .taps     (taps)
   );

   jss_stencil u_stencil (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_info    (s1_info),
      .taps       (taps),
      .epsilon    (epsilon_ff),
      .rsp_tready (rsp_tready),
      .s1_adv     (s1_adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_result (result)
   );

   // Pack the result beat, first field in the lowest bits.
   assign rsp_tdata = {5'b00000, result.converged, result.max_change,
                       result.new_temperature, result.col, result.row};
   assign rsp_tlast = result.sweep_end;

endmodule

>>> tb/sv/jacobi_sweep_tb_pkg.sv
`timescale 1ns / 100ps

package jacobi_sweep_tb_pkg;
   import jss_pkg::*;

   // Depth of each line buffer and the largest row count the block accepts.
   localparam int LINE_DEPTH = 512;
   localparam int ROWS_LIMIT = 512;

   // Scoreboard for one stencil sweep engine. It models the line buffers,
   // the position counters and the running peak change, and keeps the
   // interior points that are still due on the result channel.
   class sweep_scoreboard;
      logic [VALUE_W-1:0] line_above[LINE_DEPTH];
      logic [VALUE_W-1:0] line_above2[LINE_DEPTH];
      bit                 filled_above[LINE_DEPTH];
      bit                 filled_above2[LINE_DEPTH];
      logic [VALUE_W-1:0] west_value;
      int unsigned        row_pos;
      int unsigned        col_pos;
      logic [VALUE_W-1:0] peak_change;
      logic [GRID_W-1:0]  rows_reg;
      logic [GRID_W-1:0]  cols_reg;
      logic [VALUE_W-1:0] eps_reg;
      result_type         due_points[$];
      int                 mismatches;
      int                 points_checked;
      int                 sweeps_closed;
      int                 sweeps_converged;

      function new();
         foreach (line_above[i]) begin
            line_above[i] = '0;
            line_above2[i] = '0;
            filled_above[i] = 1'b0;
            filled_above2[i] = 1'b0;
         end
         west_value = '0;
         row_pos = 0;
         col_pos = 0;
         peak_change = '0;
         rows_reg = 10'd500;
         cols_reg = 10'd500;
         eps_reg = 24'd66;
         mismatches = 0;
         points_checked = 0;
         sweeps_closed = 0;
         sweeps_converged = 0;
      endfunction

      // Out-of-range dimensions are pulled into 3..hi.
      static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
         if (v < 3) return 3;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned rows_in_use();
         return clamp_dim(rows_reg, ROWS_LIMIT);
      endfunction

      function int unsigned cols_in_use();
         return clamp_dim(cols_reg, LINE_DEPTH);
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_GRID_ROWS: rows_reg = v[GRID_W-1:0];
            CSR_GRID_COLS: cols_reg = v[GRID_W-1:0];
            CSR_EPSILON:   eps_reg = v[VALUE_W-1:0];
            default: ;
         endcase
      endfunction

      // Number of leading columns whose entries hold real data in both lines.
      function int unsigned filled_prefix();
         int unsigned n;
         n = 0;
         while (n < LINE_DEPTH && filled_above[n] && filled_above2[n]) n++;
         return n;
      endfunction

      // A dimension change is safe at the start of a sweep, or when every
      // column the new width can read has already been written.
      function bit dims_change_ok(int unsigned new_cols);
         return (row_pos == 0 && col_pos == 0) || filled_prefix() >= new_cols;
      endfunction

      // Beats left until the counters come back to the top left corner.
      function int unsigned beats_to_sweep_end();
         int unsigned nr, nc, r, c;
         nr = rows_in_use();
         nc = cols_in_use();
         r = row_pos;
         c = col_pos;
         if (c >= nc) begin
            c = 0;
            r++;
         end
         if (r >= nr) r = 0;
         return (nr - r) * nc - c;
      endfunction

      function int pending();
         return due_points.size();
      endfunction

      // One accepted grid beat: it is the south neighbor of the point one
      // row up, so that point's new value is known now.
      function void note_temperature(logic [VALUE_W-1:0] south);
         int unsigned        nr, nc, r, c;
         logic [VALUE_W-1:0] mid, up, right, avg, delta;
         logic [VALUE_W+1:0] total;
         result_type         pt;
         nr = rows_in_use();
         nc = cols_in_use();
         // A shrunk grid moves the counters on before the beat is placed.
         if (col_pos >= nc) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= nr) begin
            row_pos = 0;
            peak_change = '0;
         end
         r = row_pos;
         c = col_pos;
         mid = line_above[c];
         up = line_above2[c];
         right = (c + 1 < LINE_DEPTH) ? line_above[c + 1] : '0;
         if (r >= 2 && c >= 1 && c + 2 <= nc) begin
            total = up + south + west_value + right;
            avg = total[VALUE_W+1:2];
            delta = (avg >= mid) ? avg - mid : mid - avg;
            if (delta > peak_change) peak_change = delta;
            pt.row = r - 1;
            pt.col = c;
            pt.new_temperature = avg;
            pt.sweep_end = (r + 1 == nr) && (c + 2 == nc);
            pt.max_change = pt.sweep_end ? peak_change : '0;
            pt.converged = pt.sweep_end && (peak_change < eps_reg);
            if (pt.sweep_end) peak_change = '0;
            due_points.push_back(pt);
         end
         // Shift this column down through both lines.
         line_above2[c] = mid;
         filled_above2[c] = filled_above[c];
         line_above[c] = south;
         filled_above[c] = 1'b1;
         west_value = mid;
         col_pos = c + 1;
         if (col_pos >= nc) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= nr) begin
               row_pos = 0;
               peak_change = '0;
            end
         end
      endfunction

      function void compare_field(string name, logic [VALUE_W-1:0] want,
                                  logic [VALUE_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
         end
      endfunction

      // One result beat against the oldest point still due.
      function void check_point(logic [RSP_DATA_W-1:0] data, logic last);
         result_type pt;
         if (due_points.size() == 0) begin
            mismatches++;
            $display("%0t ns: result beat with nothing due, expected none, actual %h/%b",
                     $time, data, last);
            return;
         end
         pt = due_points.pop_front();
         compare_field("row", pt.row, data[8:0]);
         compare_field("col", pt.col, data[17:9]);
         compare_field("new_temperature", pt.new_temperature, data[41:18]);
         compare_field("sweep_end", pt.sweep_end, last);
         compare_field("max_change", pt.max_change, data[65:42]);
         compare_field("converged", pt.converged, data[66]);
         compare_field("padding", '0, data[71:67]);
         points_checked++;
         if (pt.sweep_end) begin
            sweeps_closed++;
            if (pt.converged) sweeps_converged++;
         end
      endfunction
   endclass

endpackage

>>> tb/sv/jacobi_stencil_sweep_top_test.sv
`timescale 1ns / 100ps

module jacobi_stencil_sweep_top_test;
   import jss_pkg::*;
   import jacobi_sweep_tb_pkg::*;

   localparam int ITEM_BUDGET   = 1950;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;

   typedef enum int {
      FILL_SMOOTH,
      FILL_RANDOM,
      FILL_EXTREME
   } fill_style_e;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sweep_scoreboard grid_sb = new();
   int              beats_sent;
   int unsigned     send_calm;
   int unsigned     burst_left;
   bit              hold_off_request;

   jacobi_stencil_sweep_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Idle length for either side: mostly none or short, a few long, and
   // now and then a calm stretch with no idling at all.
   function automatic int unsigned idle_length(ref int unsigned calm_left);
      int unsigned k;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      k = $urandom_range(0, 99);
      if (k < 3) begin
         calm_left = $urandom_range(40, 150);
         return 0;
      end
      if (k < 62) return 0;
      if (k < 88) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Dimension values: mostly small grids, some below the minimum, some at
   // or beyond the buffer depth.
   function automatic int unsigned pick_dim();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 8) return $urandom_range(0, 2);
      if (k < 11) return 512;
      if (k < 13) return 1023;
      if (k < 15) return $urandom_range(513, 1023);
      return $urandom_range(3, 12);
   endfunction

   // Register word for a dimension, with junk above the 10 used bits.
   function automatic logic [CSR_DATA_W-1:0] dim_word(int unsigned d);
      logic [CSR_DATA_W-1:0] w;
      w = $urandom;
      w[GRID_W-1:0] = d[GRID_W-1:0];
      return w;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_epsilon();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 10) return '0;
      if (k < 20) return '1;
      if (k < 60) return $urandom_range(0, 255);
      return $urandom;
   endfunction

   function automatic fill_style_e pick_style();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 45) return FILL_SMOOTH;
      if (k < 85) return FILL_RANDOM;
      return FILL_EXTREME;
   endfunction

   function automatic logic [VALUE_W-1:0] next_temperature(fill_style_e style,
                                                           logic [VALUE_W-1:0] base);
      int unsigned k;
      case (style)
         FILL_SMOOTH: return base + $urandom_range(0, 15);
         FILL_RANDOM: return $urandom;
         default: begin
            k = $urandom_range(0, 2);
            if (k == 0) return '0;
            if (k == 1) return '1;
            return 24'd1 << $urandom_range(0, VALUE_W - 1);
         end
      endcase
   endfunction

   // Offer one grid beat after a random gap and wait until it is taken.
   task automatic send_temperature(input logic [VALUE_W-1:0] t);
      int unsigned gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = idle_length(send_calm);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= t;
      do @(posedge clock); while (!req_tready);
      grid_sb.note_temperature(t);
      beats_sent++;
   endtask

   // Stop offering, let every due point arrive, then let the pipe empty.
   task automatic settle_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (grid_sb.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      grid_sb.write_reg(idx, v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // A 3x3 grid whose single interior point differs from its ring.
   task automatic directed_grid(input logic [VALUE_W-1:0] center,
                                input logic [VALUE_W-1:0] ring);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            send_temperature((r == 1 && c == 1) ? center : ring);
         end
      end
   endtask

   // One full sweep at the widest grid. This also fills every buffer
   // column, so later sweeps may resize the grid mid-sweep. Part way in,
   // the result side holds off while the sender keeps pushing.
   task automatic fill_wide_sweep();
      int unsigned        count;
      fill_style_e        style;
      logic [VALUE_W-1:0] base;
      settle_idle();
      write_csr(CSR_GRID_COLS, dim_word($urandom_range(0, 1) ? 512 : 1023));
      write_csr(CSR_GRID_ROWS, dim_word($urandom_range(0, 3)));
      write_csr(CSR_EPSILON, pick_epsilon());
      count = grid_sb.beats_to_sweep_end();
      style = pick_style();
      base = $urandom_range(0, 24'hFFFFF0);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == 1100) begin
            hold_off_request = 1'b1;
            burst_left = 80;
         end
         send_temperature(next_temperature(style, base));
      end
   endtask

   // One random phase: new settings while idle, then a whole or partial sweep.
   task automatic run_phase();
      int unsigned        new_rows, new_cols, rem, count;
      fill_style_e        style;
      logic [VALUE_W-1:0] base;
      settle_idle();
      if ($urandom_range(0, 1)) write_csr(CSR_EPSILON, pick_epsilon());
      new_rows = pick_dim();
      new_cols = pick_dim();
      if ($urandom_range(0, 2) != 0 &&
          grid_sb.dims_change_ok(sweep_scoreboard::clamp_dim(new_cols, LINE_DEPTH))) begin
         write_csr(CSR_GRID_ROWS, dim_word(new_rows));
         write_csr(CSR_GRID_COLS, dim_word(new_cols));
      end
      rem = grid_sb.beats_to_sweep_end();
      if (rem <= 200 && $urandom_range(0, 3) != 0) count = rem;
      else count = $urandom_range(1, 60);
      style = pick_style();
      base = $urandom_range(0, 24'hFFFFF0);
      repeat (count) send_temperature(next_temperature(style, base));
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : rsp_sink
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned recv_calm;
      logic        ready_next;
      rsp_tready = 1'b0;
      stall_left = 0;
      hold_left = 0;
      recv_calm = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (stall_left == 0) stall_left = idle_length(recv_calm);
            if (stall_left > 0) begin
               stall_left--;
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
            end
         end
         rsp_tready <= ready_next;
      end
   end

   // Every accepted result beat goes straight to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) grid_sb.check_point(rsp_tdata, rsp_tlast);
   end

   initial begin : stimulus
      int directed_beats;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_GRID_ROWS;
      csr_wdata = '0;
      beats_sent = 0;
      send_calm = 0;
      burst_left = 0;
      hold_off_request = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest grid through clamping, small change under the reset tolerance.
      write_csr(CSR_GRID_ROWS, 24'd0);
      write_csr(CSR_GRID_COLS, 24'd2);
      directed_grid(24'd1040, 24'd1000);
      // Full-scale change against the largest tolerance: equal is not below.
      settle_idle();
      write_csr(CSR_EPSILON, '1);
      directed_grid('0, '1);
      directed_beats = beats_sent;

      fill_wide_sweep();
      while (beats_sent - directed_beats < ITEM_BUDGET) run_phase();
      settle_idle();

      $display("Streamed %0d grid beats and checked %0d interior points.",
               beats_sent, grid_sb.points_checked);
      $display("Closed %0d sweeps, %0d of them converged; %0d mismatches seen.",
               grid_sb.sweeps_closed, grid_sb.sweeps_converged, grid_sb.mismatches);
      if (grid_sb.mismatches == 0 && grid_sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #8000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
